FILE: design/cusa_pkg.sv
// Shared types, codes and limits of the coding-block split allowance block.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package cusa_pkg;

    // Fixed limits of the partition rules
    localparam int MAX_TU_SIZE      = 64;
    localparam int MIN_CHROMA_WIDTH = 4;
    localparam int MIN_CHROMA_AREA  = 16;
    localparam int DUAL_MAX_SIDE    = 64;
    localparam int CW_MIN_BV        = 4;
    localparam int CW_MIN_TV        = 8;
    localparam int INTER_BT_AREA    = 32;
    localparam int INTER_TT_AREA    = 64;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MTT_DEPTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CB_SIZE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BT_SIZE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TT_SIZE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_QT_SIZE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PIC_WIDTH     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PIC_HEIGHT    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DUAL_TREE     = 3'd7;

    // Parent split codes
    typedef enum logic [2:0] {
        SPLIT_CTU  = 3'd0,
        SPLIT_QUAD = 3'd1,
        SPLIT_BT_H = 3'd2,
        SPLIT_BT_V = 3'd3,
        SPLIT_TT_H = 3'd4,
        SPLIT_TT_V = 3'd5
    } split_t;

    // Tree kind codes
    localparam logic [1:0] TREE_LUMA   = 2'd0;
    localparam logic [1:0] TREE_CHROMA = 2'd1;

    typedef struct packed {
        logic [3:0]  max_mtt_depth;
        logic [6:0]  min_cb_size;
        logic [7:0]  max_bt_size;
        logic [7:0]  max_tt_size;
        logic [7:0]  min_qt_size;
        logic [13:0] pic_width;
        logic [13:0] pic_height;
        logic        dual_tree;
    } cfg_t;

    typedef struct packed {
        logic [12:0] blk_x;
        logic [12:0] blk_y;
        logic [7:0]  blk_w;
        logic [7:0]  blk_h;
        logic [2:0]  last_split;
        logic [1:0]  part_index;
        logic [3:0]  mt_depth;
        logic [2:0]  implicit_bt_depth;
        logic [1:0]  tree_mode;
        logic [6:0]  chroma_w;
        logic [6:0]  chroma_h;
        logic        inter_only;
    } item_t;

    typedef struct packed {
        logic can_no;
        logic can_qt;
        logic can_bh;
        logic can_bv;
        logic can_th;
        logic can_tv;
    } result_t;

endpackage

`default_nettype wire

FILE: design/cusa_cfg_regs.sv
// Configuration register file of the split allowance block.
// Depends on cusa_pkg for the register indexes and the cfg_t bundle.
`default_nettype none

module cusa_cfg_regs
    import cusa_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write and keep the low bits of the data word
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_MAX_MTT_DEPTH: cfg_next.max_mtt_depth = cfg_wdata[3:0];
                CFG_MIN_CB_SIZE:   cfg_next.min_cb_size   = cfg_wdata[6:0];
                CFG_MAX_BT_SIZE:   cfg_next.max_bt_size   = cfg_wdata[7:0];
                CFG_MAX_TT_SIZE:   cfg_next.max_tt_size   = cfg_wdata[7:0];
                CFG_MIN_QT_SIZE:   cfg_next.min_qt_size   = cfg_wdata[7:0];
                CFG_PIC_WIDTH:     cfg_next.pic_width     = cfg_wdata[13:0];
                CFG_PIC_HEIGHT:    cfg_next.pic_height    = cfg_wdata[13:0];
                CFG_DUAL_TREE:     cfg_next.dual_tree     = cfg_wdata[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers, load defaults on reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_mtt_depth <= 4'd3;
            cfg_reg.min_cb_size   <= 7'd4;
            cfg_reg.max_bt_size   <= 8'd128;
            cfg_reg.max_tt_size   <= 8'd64;
            cfg_reg.min_qt_size   <= 8'd8;
            cfg_reg.pic_width     <= 14'd1920;
            cfg_reg.pic_height    <= 14'd1080;
            cfg_reg.dual_tree     <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: design/cusa_decide.sv
// Split permission rules for one block descriptor, purely combinational.
// Depends on cusa_pkg for the item, configuration and result bundles.
`default_nettype none

module cusa_decide
    import cusa_pkg::*;
(
    input  wire cfg_t  cfg,
    input  wire item_t item,
    output result_t    res
);

    logic [7:0]  w;
    logic [7:0]  h;
    logic [7:0]  min_cb;
    logic [7:0]  min_cb_x2;
    logic [13:0] carea;
    logic [15:0] larea;
    logic [4:0]  depth_lim;
    logic [13:0] right_edge;
    logic [13:0] bottom_edge;
    logic        chroma;
    logic        chroma_only;
    logic        dual_big;
    logic        right_in;
    logic        bottom_in;
    logic        btt;
    logic        btt_all;
    logic        qt_base;
    logic        bt_fits;
    logic        tt_fits;
    logic        bt_ok;
    logic        qt_b1;
    logic        bh_b;
    logic        bv_b;
    logic        tt_mid;
    logic        bh_i;
    logic        bv_i;
    logic        th_i;
    logic        tv_i;

    // Sizes, areas and edges at full width so nothing wraps
    always_comb begin
        w           = item.blk_w;
        h           = item.blk_h;
        min_cb      = {1'b0, cfg.min_cb_size};
        min_cb_x2   = {cfg.min_cb_size, 1'b0};
        carea       = 14'(item.chroma_w) * 14'(item.chroma_h);
        larea       = 16'(w) * 16'(h);
        depth_lim   = 5'(cfg.max_mtt_depth) + 5'(item.implicit_bt_depth);
        right_edge  = 14'(item.blk_x) + 14'(w);
        bottom_edge = 14'(item.blk_y) + 14'(h);
        right_in    = right_edge <= cfg.pic_width;
        bottom_in   = bottom_edge <= cfg.pic_height;
        chroma      = item.tree_mode == TREE_CHROMA;
        chroma_only = item.tree_mode[1];
        dual_big    = cfg.dual_tree &&
                      (w > 8'(DUAL_MAX_SIDE) || h > 8'(DUAL_MAX_SIDE));
        btt         = 5'(item.mt_depth) < depth_lim;
        bt_fits     = w <= cfg.max_bt_size && h <= cfg.max_bt_size;
        tt_fits     = w <= cfg.max_tt_size && h <= cfg.max_tt_size;
    end

    // Quad split base rule
    assign qt_base = (item.last_split == SPLIT_CTU || item.last_split == SPLIT_QUAD) &&
                     (w > cfg.min_qt_size) &&
                     !(chroma && item.chroma_w <= 7'(MIN_CHROMA_WIDTH));

    // Forced splits across the picture boundary
    always_comb begin
        bt_ok = bt_fits && w <= 8'(MAX_TU_SIZE) && h <= 8'(MAX_TU_SIZE) && btt;
        qt_b1 = qt_base || !bt_ok;
        bh_b  = bt_ok && !bottom_in && (right_in || !qt_b1);
        bv_b  = bt_ok && bottom_in && !right_in &&
                !(chroma && item.chroma_w <= 7'(CW_MIN_BV));
    end

    // Interior rules for binary and ternary splits
    always_comb begin
        btt_all = btt && (w > min_cb || h > min_cb) && (bt_fits || tt_fits);
        tt_mid  = (item.last_split == SPLIT_TT_H || item.last_split == SPLIT_TT_V) &&
                  item.part_index == 2'd1;

        if (!bt_fits || (item.inter_only && larea == 16'(INTER_BT_AREA))) begin
            bh_i = 1'b0;
            bv_i = 1'b0;
        end else begin
            bh_i = !(tt_mid && item.last_split == SPLIT_TT_H);
            bv_i = !(tt_mid && item.last_split == SPLIT_TT_V);
            bh_i = bh_i && h > min_cb && h <= cfg.max_bt_size &&
                   (w <= 8'(MAX_TU_SIZE) || h > 8'(MAX_TU_SIZE));
            bv_i = bv_i && w > min_cb && w <= cfg.max_bt_size &&
                   (w > 8'(MAX_TU_SIZE) || h <= 8'(MAX_TU_SIZE));
        end

        if (!tt_fits || (item.inter_only && larea == 16'(INTER_TT_AREA)) ||
            w > 8'(MAX_TU_SIZE) || h > 8'(MAX_TU_SIZE)) begin
            th_i = 1'b0;
            tv_i = 1'b0;
        end else begin
            th_i = h > min_cb_x2;
            tv_i = w > min_cb_x2;
        end

        // Chroma minimum areas and widths
        if (chroma) begin
            bh_i = bh_i && carea > 14'(MIN_CHROMA_AREA);
            th_i = th_i && carea > 14'(2 * MIN_CHROMA_AREA);
            bv_i = bv_i && carea > 14'(MIN_CHROMA_AREA) &&
                   item.chroma_w > 7'(CW_MIN_BV);
            tv_i = tv_i && carea > 14'(2 * MIN_CHROMA_AREA) &&
                   item.chroma_w > 7'(CW_MIN_TV);
        end
    end

    // Pick the rule set that applies, in priority order
    always_comb begin
        res = '0;
        if (dual_big) begin
            res.can_qt = 1'b1;
        end else if (chroma_only) begin
            res.can_no = 1'b1;
        end else if (!right_in || !bottom_in) begin
            res.can_qt = qt_b1 || (!bh_b && !bv_b);
            res.can_bh = bh_b;
            res.can_bv = bv_b;
        end else if (!btt_all) begin
            res.can_no = 1'b1;
            res.can_qt = qt_base;
        end else begin
            res.can_no = 1'b1;
            res.can_qt = qt_base;
            res.can_bh = bh_i;
            res.can_bv = bv_i;
            res.can_th = th_i;
            res.can_tv = tv_i;
        end
    end

endmodule

`default_nettype wire

FILE: design/cu_split_allowance.sv
// Top level of the coding-block split allowance block: input register,
// rule logic, result register. Depends on cusa_pkg, cusa_cfg_regs, cusa_decide.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  cfg     | in        | cfg_wr_en          | cfg_index, cfg_wdata
//  s_      | in        | s_valid / s_ready  | block descriptor word
//  m_      | out       | m_valid / m_ready  | six split permission flags
//
// Each word is held in the input register, then goes through the rule logic
// into the result register.
// A new word is accepted every cycle while results are taken.
// Synchronous active-low reset clears both valid flags and reloads defaults.
// When m_ready is low the result holds and the input register fills only if empty.
`default_nettype none

module cu_split_allowance
    import cusa_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [12:0]           s_blk_x,
    input  wire logic [12:0]           s_blk_y,
    input  wire logic [7:0]            s_blk_w,
    input  wire logic [7:0]            s_blk_h,
    input  wire logic [2:0]            s_last_split,
    input  wire logic [1:0]            s_part_index,
    input  wire logic [3:0]            s_mt_depth,
    input  wire logic [2:0]            s_implicit_bt_depth,
    input  wire logic [1:0]            s_tree_mode,
    input  wire logic [6:0]            s_chroma_w,
    input  wire logic [6:0]            s_chroma_h,
    input  wire logic                  s_inter_only,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_can_no,
    output logic                       m_can_qt,
    output logic                       m_can_bh,
    output logic                       m_can_bv,
    output logic                       m_can_th,
    output logic                       m_can_tv
);

    cfg_t    cfg;
    item_t   s_item;
    item_t   item_reg;
    logic    in_vld_reg;
    result_t res_comb;
    result_t res_reg;
    logic    res_vld_reg;
    logic    advance;

    cusa_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Gather the input ports into one word
    always_comb begin
        s_item.blk_x             = s_blk_x;
        s_item.blk_y             = s_blk_y;
        s_item.blk_w             = s_blk_w;
        s_item.blk_h             = s_blk_h;
        s_item.last_split        = s_last_split;
        s_item.part_index        = s_part_index;
        s_item.mt_depth          = s_mt_depth;
        s_item.implicit_bt_depth = s_implicit_bt_depth;
        s_item.tree_mode         = s_tree_mode;
        s_item.chroma_w          = s_chroma_w;
        s_item.chroma_h          = s_chroma_h;
        s_item.inter_only        = s_inter_only;
    end

    // Advance when the result slot is empty or being taken
    assign advance = !res_vld_reg || m_ready;
    assign s_ready = !in_vld_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end

    cusa_decide u_decide (
        .cfg  (cfg),
        .item (item_reg),
        .res  (res_comb)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_vld_reg <= 1'b0;
        end else if (advance) begin
            res_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_vld_reg) begin
            res_reg <= res_comb;
        end
    end

    assign m_valid  = res_vld_reg;
    assign m_can_no = res_reg.can_no;
    assign m_can_qt = res_reg.can_qt;
    assign m_can_bh = res_reg.can_bh;
    assign m_can_bv = res_reg.can_bv;
    assign m_can_th = res_reg.can_th;
    assign m_can_tv = res_reg.can_tv;

endmodule

`default_nettype wire

FILE: bench/cusa_checker.sv
`timescale 1ns / 1ps
// Checker for the split allowance block: watches the register port and both
// channels, predicts each result word and compares it flag by flag.
// Depends on cusa_pkg for the word layouts and register indexes.

module cusa_checker
    import cusa_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  item_t                 s_word,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  result_t               m_flags,
    output int                    mismatches,
    output int                    pending,
    output int                    words_in,
    output int                    words_out
);

    // Index of the middle part of a ternary split
    localparam logic [1:0] MID_PART = 2'd1;
    // Cap on printed mismatch lines; every mismatch is still counted
    localparam int REPORT_MAX = 30;

    cfg_t    regs;
    result_t flags_due[$];
    string   flag_name [0:5] = '{"can_no", "can_qt", "can_bh", "can_bv", "can_th", "can_tv"};

    // Work out the six split permissions of one block descriptor
    function automatic result_t split_allowance(input item_t d, input cfg_t c);
        result_t    r;
        int         x, y, w, h, cw, ch, carea;
        int         mcb, mbt, mtt, mqt, pw, ph;
        logic [2:0] ls;
        logic       is_chroma, is_inter, btt, bt_ok, right_in, bottom_in;
        logic       qt, bh, bv, th, tv;
        x = d.blk_x;
        y = d.blk_y;
        w = d.blk_w;
        h = d.blk_h;
        cw = d.chroma_w;
        ch = d.chroma_h;
        carea = cw * ch;
        mcb = c.min_cb_size;
        mbt = c.max_bt_size;
        mtt = c.max_tt_size;
        mqt = c.min_qt_size;
        pw = c.pic_width;
        ph = c.pic_height;
        ls = d.last_split;
        is_chroma = (d.tree_mode == TREE_CHROMA);
        is_inter = d.inter_only;
        btt = int'(d.mt_depth) < int'(c.max_mtt_depth) + int'(d.implicit_bt_depth);
        r = '0;

        // large block in a dual tree: quad split only
        if (c.dual_tree && (w > DUAL_MAX_SIDE || h > DUAL_MAX_SIDE)) begin
            r.can_qt = 1'b1;
            return r;
        end
        // chroma-only tree (and the unused code after it): leave unsplit
        if (d.tree_mode > TREE_CHROMA) begin
            r.can_no = 1'b1;
            return r;
        end

        right_in = (x + w) <= pw;
        bottom_in = (y + h) <= ph;

        qt = 1'b1;
        if (ls != SPLIT_CTU && ls != SPLIT_QUAD) qt = 1'b0;
        if (w <= mqt) qt = 1'b0;
        if (is_chroma && cw <= MIN_CHROMA_WIDTH) qt = 1'b0;

        // picture boundary: forced split, no ternary, never unsplit
        if (!right_in || !bottom_in) begin
            bt_ok = w <= mbt && h <= mbt && w <= MAX_TU_SIZE && h <= MAX_TU_SIZE && btt;
            qt = qt || !bt_ok;
            bh = bt_ok && !bottom_in && (right_in || !qt);
            bv = bt_ok && bottom_in && !right_in;
            if (is_chroma && !(cw > CW_MIN_BV)) bv = 1'b0;
            qt = qt || (!bh && !bv);
            r.can_qt = qt;
            r.can_bh = bh;
            r.can_bv = bv;
            return r;
        end

        btt = btt && (w > mcb || h > mcb);
        btt = btt && ((w <= mbt && h <= mbt) || (w <= mtt && h <= mtt));
        r.can_no = 1'b1;
        r.can_qt = qt;
        if (!btt) return r;

        // binary splits
        if (w > mbt || h > mbt || (is_inter && w * h == INTER_BT_AREA)) begin
            bh = 1'b0;
            bv = 1'b0;
        end else begin
            bh = 1'b1;
            bv = 1'b1;
            // no binary split parallel to the middle part of a ternary split
            if ((ls == SPLIT_TT_H || ls == SPLIT_TT_V) && d.part_index == MID_PART) begin
                bh = (ls != SPLIT_TT_H);
                bv = (ls != SPLIT_TT_V);
            end
            bh = bh && h > mcb && h <= mbt;
            bh = bh && (w <= MAX_TU_SIZE || h > MAX_TU_SIZE);
            bv = bv && w > mcb && w <= mbt;
            bv = bv && (w > MAX_TU_SIZE || h <= MAX_TU_SIZE);
        end

        // ternary splits
        if (w > mtt || h > mtt || (is_inter && w * h == INTER_TT_AREA) ||
            w > MAX_TU_SIZE || h > MAX_TU_SIZE) begin
            th = 1'b0;
            tv = 1'b0;
        end else begin
            th = h > 2 * mcb;
            tv = w > 2 * mcb;
        end

        // chroma minimum areas and widths
        if (is_chroma) begin
            bh = bh && carea > MIN_CHROMA_AREA;
            th = th && carea > 2 * MIN_CHROMA_AREA;
            bv = bv && carea > MIN_CHROMA_AREA && cw > CW_MIN_BV;
            tv = tv && carea > 2 * MIN_CHROMA_AREA && cw > CW_MIN_TV;
        end

        r.can_bh = bh;
        r.can_bv = bv;
        r.can_th = th;
        r.can_tv = tv;
        return r;
    endfunction

    initial begin
        mismatches = 0;
        pending = 0;
        words_in = 0;
        words_out = 0;
    end

    // Compare the result word first, then queue the new query, then take writes
    always @(posedge aclk) begin : watch
        result_t want;
        if (!aresetn) begin
            regs = '{max_mtt_depth: 4'd3, min_cb_size: 7'd4, max_bt_size: 8'd128,
                     max_tt_size: 8'd64, min_qt_size: 8'd8, pic_width: 14'd1920,
                     pic_height: 14'd1080, dual_tree: 1'b0};
            flags_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                words_out++;
                if (flags_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t ns: result word %b arrived with no query outstanding",
                                 $time, m_flags);
                end else begin
                    want = flags_due.pop_front();
                    for (int i = 0; i < 6; i++) begin
                        if (want[5-i] !== m_flags[5-i]) begin
                            mismatches++;
                            if (mismatches <= REPORT_MAX)
                                $display("%0t ns: result %0d %s expected %b got %b",
                                         $time, words_out, flag_name[i], want[5-i],
                                         m_flags[5-i]);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                flags_due.push_back(split_allowance(s_word, regs));
                words_in++;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_MAX_MTT_DEPTH: regs.max_mtt_depth = cfg_wdata[3:0];
                    CFG_MIN_CB_SIZE:   regs.min_cb_size = cfg_wdata[6:0];
                    CFG_MAX_BT_SIZE:   regs.max_bt_size = cfg_wdata[7:0];
                    CFG_MAX_TT_SIZE:   regs.max_tt_size = cfg_wdata[7:0];
                    CFG_MIN_QT_SIZE:   regs.min_qt_size = cfg_wdata[7:0];
                    CFG_PIC_WIDTH:     regs.pic_width = cfg_wdata[13:0];
                    CFG_PIC_HEIGHT:    regs.pic_height = cfg_wdata[13:0];
                    CFG_DUAL_TREE:     regs.dual_tree = cfg_wdata[0];
                    default: ;
                endcase
            end
        end
        pending = flags_due.size();
    end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// Top of the split allowance bench: clock, reset, register settings, query
// words and result back-pressure. Depends on cusa_pkg, cu_split_allowance, cusa_checker.

module testbench;
    import cusa_pkg::*;

    // Codes the package leaves unnamed
    localparam logic [2:0] SPLIT_RESERVED_LO = 3'd6;
    localparam logic [2:0] SPLIT_RESERVED_HI = 3'd7;
    localparam logic [1:0] TREE_CHROMA_ONLY  = 2'd2;
    localparam logic [1:0] TREE_UNUSED       = 2'd3;

    localparam int PHASES      = 12;
    localparam int PHASE_WORDS = 165;
    localparam int QUIET_LIMIT = 2000;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    item_t                 blk;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_can_no, m_can_qt, m_can_bh, m_can_bv, m_can_th, m_can_tv;
    result_t               m_flags;

    int mismatches, pending, words_in, words_out;
    int sender_idle_pct = 0;
    int sink_stall_pct = 0;
    int pic_w_now = 1920;
    int pic_h_now = 1080;

    assign m_flags = {m_can_no, m_can_qt, m_can_bh, m_can_bv, m_can_th, m_can_tv};

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    cu_split_allowance uut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_blk_x             (blk.blk_x),
        .s_blk_y             (blk.blk_y),
        .s_blk_w             (blk.blk_w),
        .s_blk_h             (blk.blk_h),
        .s_last_split        (blk.last_split),
        .s_part_index        (blk.part_index),
        .s_mt_depth          (blk.mt_depth),
        .s_implicit_bt_depth (blk.implicit_bt_depth),
        .s_tree_mode         (blk.tree_mode),
        .s_chroma_w          (blk.chroma_w),
        .s_chroma_h          (blk.chroma_h),
        .s_inter_only        (blk.inter_only),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_can_no            (m_can_no),
        .m_can_qt            (m_can_qt),
        .m_can_bh            (m_can_bh),
        .m_can_bv            (m_can_bv),
        .m_can_th            (m_can_th),
        .m_can_tv            (m_can_tv)
    );

    cusa_checker u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_word     (blk),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_flags    (m_flags),
        .mismatches (mismatches),
        .pending    (pending),
        .words_in   (words_in),
        .words_out  (words_out)
    );

    // Result back-pressure, redrawn every cycle
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready = ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // End the run when neither channel moves a word for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("watchdog: no word moved in %0d cycles", QUIET_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    function automatic item_t mk(input int x, input int y, input int w, input int h,
                                 input logic [2:0] ls, input int pidx, input int mtd,
                                 input int ibtd, input logic [1:0] tm, input int cw,
                                 input int ch, input int inter);
        item_t d;
        d.blk_x = x[12:0];
        d.blk_y = y[12:0];
        d.blk_w = w[7:0];
        d.blk_h = h[7:0];
        d.last_split = ls;
        d.part_index = pidx[1:0];
        d.mt_depth = mtd[3:0];
        d.implicit_bt_depth = ibtd[2:0];
        d.tree_mode = tm;
        d.chroma_w = cw[6:0];
        d.chroma_h = ch[6:0];
        d.inter_only = inter[0];
        return d;
    endfunction

    // Mostly power-of-two sides, now and then any 8-bit value
    function automatic int pick_side();
        if ($urandom_range(0, 15) == 0) return $urandom_range(0, 255);
        return 4 << $urandom_range(0, 5);
    endfunction

    // Random descriptor, pulled towards the picture edges part of the time
    function automatic item_t random_word();
        int w, h, x, y, pos, tsel, cw, ch;
        w = pick_side();
        h = pick_side();
        pos = $urandom_range(0, 9);
        if (pos == 0) begin
            x = $urandom_range(0, 8191);
            y = $urandom_range(0, 8191);
        end else begin
            x = int'($urandom_range(0, pic_w_now)) & ~3;
            y = int'($urandom_range(0, pic_h_now)) & ~3;
            if (pos == 1 || pos == 2 || pos == 5) x = pic_w_now - int'($urandom_range(0, 2 * w));
            if (pos == 3 || pos == 4 || pos == 5) y = pic_h_now - int'($urandom_range(0, 2 * h));
            if (x < 0) x = 0;
            if (y < 0) y = 0;
        end
        tsel = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0) begin
            cw = $urandom_range(0, 127);
            ch = $urandom_range(0, 127);
        end else begin
            cw = (w / 2 > 127) ? 127 : w / 2;
            ch = (h / 2 > 127) ? 127 : h / 2;
        end
        return mk(x, y, w, h, 3'($urandom_range(0, 7)), $urandom_range(0, 3),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 4),
                  ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 7),
                  (tsel < 5) ? TREE_LUMA : (tsel < 9) ? TREE_CHROMA : 2'($urandom_range(2, 3)),
                  cw, ch, $urandom_range(0, 1));
    endfunction

    // Called at a falling edge; blocking drives settle well before the rising edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val[CFG_DATA_W-1:0];
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // Offer one query word, with random idle cycles ahead of it; return at a falling edge
    task automatic send_word(input item_t d);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        blk = d;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Drop valid and hold until every result is back
    task automatic drain();
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Write all eight registers for one phase
    task automatic program_regs(input int kind);
        int v [0:7];
        // value order follows the register indexes
        case (kind)
            0: v = '{3, 4, 128, 64, 8, 1920, 1080, 0};
            1: v = '{0, 4, 4, 4, 4, 8, 8, 0};
            2: v = '{10, 64, 128, 128, 128, 8192, 8192, 1};
            3: v = '{15, 127, 255, 255, 255, 16383, 16383, 1};
            default: begin
                v[CFG_MAX_MTT_DEPTH] = $urandom_range(0, 10);
                v[CFG_MIN_CB_SIZE] = 4 << $urandom_range(0, 4);
                v[CFG_MAX_BT_SIZE] = 4 << $urandom_range(0, 5);
                v[CFG_MAX_TT_SIZE] = 4 << $urandom_range(0, 5);
                v[CFG_MIN_QT_SIZE] = 4 << $urandom_range(0, 5);
                v[CFG_PIC_WIDTH] = 8 * $urandom_range(1, 1024);
                v[CFG_PIC_HEIGHT] = 8 * $urandom_range(1, 1024);
                v[CFG_DUAL_TREE] = $urandom_range(0, 1);
            end
        endcase
        for (int i = 0; i < 8; i++) write_reg(i[CFG_IDX_W-1:0], v[i]);
        pic_w_now = v[CFG_PIC_WIDTH];
        pic_h_now = v[CFG_PIC_HEIGHT];
    endtask

    initial begin
        item_t directed[$];
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        blk = '0;
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        // Directed words on the reset settings with the dual tree on
        write_reg(CFG_DUAL_TREE, 1);
        directed = '{
            mk(0, 0, 128, 128, SPLIT_CTU, 0, 0, 0, TREE_LUMA, 64, 64, 0),
            mk(8191, 8191, 255, 255, SPLIT_QUAD, 3, 15, 7, TREE_LUMA, 127, 127, 1),
            mk(0, 0, 64, 64, SPLIT_QUAD, 0, 0, 0, TREE_LUMA, 32, 32, 0),
            mk(0, 0, 4, 4, SPLIT_BT_H, 0, 2, 0, TREE_LUMA, 2, 2, 0),
            mk(0, 0, 0, 0, SPLIT_CTU, 0, 0, 0, TREE_LUMA, 0, 0, 0),
            mk(8191, 8191, 64, 64, SPLIT_CTU, 0, 0, 0, TREE_LUMA, 32, 32, 0),
            mk(1888, 0, 64, 64, SPLIT_CTU, 0, 0, 0, TREE_LUMA, 32, 32, 0),
            mk(0, 1056, 64, 64, SPLIT_QUAD, 2, 0, 0, TREE_LUMA, 32, 32, 0),
            mk(1888, 0, 64, 64, SPLIT_CTU, 0, 0, 0, TREE_CHROMA, 4, 32, 0),
            mk(1904, 1064, 32, 32, SPLIT_BT_V, 1, 3, 2, TREE_LUMA, 16, 16, 0),
            mk(64, 64, 32, 32, SPLIT_BT_V, 1, 1, 0, TREE_CHROMA_ONLY, 16, 16, 0),
            mk(64, 64, 32, 32, SPLIT_BT_V, 1, 1, 0, TREE_UNUSED, 16, 16, 0),
            mk(64, 64, 32, 32, SPLIT_RESERVED_LO, 0, 1, 0, TREE_LUMA, 16, 16, 0),
            mk(64, 64, 32, 32, SPLIT_RESERVED_HI, 1, 1, 0, TREE_LUMA, 16, 16, 0),
            mk(64, 64, 32, 16, SPLIT_TT_H, 1, 1, 0, TREE_LUMA, 16, 8, 0),
            mk(64, 64, 16, 32, SPLIT_TT_V, 1, 1, 0, TREE_LUMA, 8, 16, 0),
            mk(64, 64, 8, 4, SPLIT_BT_H, 0, 1, 0, TREE_LUMA, 4, 2, 1),
            mk(64, 64, 8, 8, SPLIT_BT_V, 0, 1, 0, TREE_LUMA, 4, 4, 1),
            mk(64, 64, 32, 32, SPLIT_BT_H, 0, 15, 0, TREE_LUMA, 16, 16, 0),
            mk(64, 64, 32, 32, SPLIT_BT_H, 0, 9, 7, TREE_LUMA, 16, 16, 0),
            mk(64, 64, 16, 16, SPLIT_QUAD, 0, 0, 0, TREE_CHROMA, 8, 8, 0),
            mk(64, 64, 8, 8, SPLIT_QUAD, 0, 0, 0, TREE_CHROMA, 4, 4, 0),
            mk(64, 64, 64, 64, SPLIT_CTU, 0, 0, 0, TREE_CHROMA, 127, 127, 0)
        };
        foreach (directed[i]) send_word(directed[i]);
        drain();

        // Random words over several settings and flow-control mixes
        for (int p = 0; p < PHASES; p++) begin
            program_regs(p);
            case (p % 4)
                0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin sender_idle_pct = 77; sink_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  sink_stall_pct = 77; end
                default: begin sender_idle_pct = 17; sink_stall_pct = 17; end
            endcase
            repeat (PHASE_WORDS) send_word(random_word());
            drain();
        end

        $display("run covered %0d queries and %0d checked results", words_in, words_out);
        $display("across %0d register settings under four flow-control mixes", PHASES + 1);
        if (mismatches == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d results outstanding", mismatches, pending);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
